// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a stalled word keeps its payload.
`define ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

// ===== design/gfprt_pkg.sv =====
// ----------------------------------------------------------------------------
// gfprt_pkg
// Shared constants, types and state codes of the response-time analysis block.
// ----------------------------------------------------------------------------
package gfprt_pkg;

  localparam int MAX_TASKS   = 16;
  localparam int IDX_W       = $clog2(MAX_TASKS);
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);
  localparam int LANES       = MAX_TASKS - 1;
  localparam int TIME_W      = 16;
  localparam int RESP_W      = 20;
  localparam int WIN_W       = RESP_W + 1;
  localparam int SUM_W       = WIN_W + $clog2(2 * MAX_TASKS);
  localparam int PROD_W      = WIN_W + TIME_W;
  localparam int PROC_W      = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIVC_W      = $clog2(SUM_W + 1);
  localparam int TASK_W      = 2 * TIME_W;

  localparam logic [RESP_W-1:0] RESP_MAX = '1;

  // Register index, taken from paddr bit 2.
  localparam logic REG_PROCESSORS = 1'b0;

  typedef struct packed {
    logic [TIME_W-1:0] wcet;
    logic [TIME_W-1:0] period;
    logic              last;
    logic              keep;
  } item_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_TASK_RD,
    S_TASK_LAT,
    S_CHECK,
    S_OM_RD,
    S_OM_LAT,
    S_DIV1,
    S_MUL1,
    S_WL1,
    S_DIV2,
    S_MUL2,
    S_WL2,
    S_SUMD,
    S_DIVM,
    S_EMIT
  } state_e;

endpackage

// ===== design/gfprt_ram.sv =====
// ----------------------------------------------------------------------------
// gfprt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfprt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/gfprt_fifo.sv =====
// ----------------------------------------------------------------------------
// gfprt_fifo
// Short queue of classified task words between the front and the back.
// ----------------------------------------------------------------------------
module gfprt_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gfprt_pkg::item_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output gfprt_pkg::item_t pop_item_o
);
  import gfprt_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/gfprt_front.sv =====
// ----------------------------------------------------------------------------
// gfprt_front
// Accept task words, fix a zero period and mark words beyond the store.
// ----------------------------------------------------------------------------
module gfprt_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [gfprt_pkg::TASK_W-1:0]   s_tdata_i,
  input  logic                           s_tlast_i,
  input  logic                           full_i,
  output logic                           push_o,
  output gfprt_pkg::item_t               push_item_o
);
  import gfprt_pkg::*;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] period;
  logic              keep;

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && s_tready_o;
  assign period     = s_tdata_i[TASK_W-1:TIME_W];
  assign keep       = (cnt_q < CNT_W'(MAX_TASKS));

  always_comb begin
    push_item_o.wcet   = s_tdata_i[TIME_W-1:0];
    push_item_o.period = (period == '0) ? TIME_W'(1) : period;
    push_item_o.last   = s_tlast_i;
    push_item_o.keep   = keep;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (s_tlast_i) begin
        cnt_d = '0;
      end else if (keep) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/gfprt_div.sv =====
// ----------------------------------------------------------------------------
// gfprt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gfprt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gfprt_pkg::SUM_W-1:0]   dividend_i,
  input  logic [gfprt_pkg::TIME_W-1:0]  divisor_i,
  output logic                          busy_o,
  output logic [gfprt_pkg::SUM_W-1:0]   quot_o,
  output logic [gfprt_pkg::TIME_W-1:0]  rem_o
);
  import gfprt_pkg::*;

  logic [SUM_W-1:0]  dv_q;
  logic [TIME_W-1:0] rem_q, dvs_q;
  logic [DIVC_W-1:0] cnt_q;
  logic [TIME_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, dv_q[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});
  assign busy_o = (cnt_q != '0);
  assign quot_o = dv_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= ge ? TIME_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[TIME_W-1:0];
      dv_q  <= {dv_q[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIVC_W'(SUM_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== design/gfprt_back.sv =====
// ----------------------------------------------------------------------------
// gfprt_back
// Store the task set and run the fixed-point response-time iteration.
// ----------------------------------------------------------------------------
module gfprt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gfprt_pkg::PROC_W-1:0]  m_i,
  input  logic                          q_valid_i,
  input  gfprt_pkg::item_t              q_item_i,
  output logic                          q_pop_o,
  output logic                          res_tvalid_o,
  input  logic                          res_tready_i,
  output logic [23:0]                   res_tdata_o,
  output logic                          res_tuser_o,
  output logic                          res_tlast_o
);
  import gfprt_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  tc_q, n_q, take_q;
  logic [IDX_W-1:0]  k_q, i_q;
  logic [TIME_W-1:0] ck_q, pk_q, ci_q, pi_q, rem_q;
  logic [RESP_W-1:0] r_q, ri_q;
  logic [WIN_W-1:0]  cap_q, q_q, nc_q;
  logic [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]  sum_q;
  logic [WIN_W-1:0]  slot_q [LANES];
  logic [WIN_W-1:0]  slot_ins [LANES];

  logic [IDX_W-1:0]  raddr;
  logic              task_we, resp_we, out_load;
  logic [TASK_W-1:0] task_rd;
  logic [RESP_W-1:0] resp_rd;

  logic              div_start, div_busy;
  logic [SUM_W-1:0]  div_dividend, div_quot;
  logic [TIME_W-1:0] div_divisor, div_rem;

  logic [TIME_W-1:0] part;
  logic [PROD_W:0]   wl;
  logic [WIN_W-1:0]  clamped, diff, win2;
  logic [SUM_W:0]    tot;
  logic [RESP_W-1:0] nxt;
  logic              miss, final_res, below_m, last_i;
  logic [PROC_W-1:0] m1;
  logic [CNT_W-1:0]  take_init;

  gfprt_ram #(.Width(TASK_W), .Depth(MAX_TASKS)) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (task_we),
    .waddr_i (tc_q[IDX_W-1:0]),
    .wdata_i ({q_item_i.period, q_item_i.wcet}),
    .raddr_i (raddr),
    .rdata_o (task_rd)
  );

  gfprt_ram #(.Width(RESP_W), .Depth(MAX_TASKS)) u_resp_ram (
    .clk_i   (clk_i),
    .we_i    (resp_we),
    .waddr_i (k_q),
    .wdata_i (r_q),
    .raddr_i (raddr),
    .rdata_o (resp_rd)
  );

  gfprt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Workload clamp: n*C + min(C, w mod P), capped at the window cap.
  assign part    = (ci_q < rem_q) ? ci_q : rem_q;
  assign wl      = {1'b0, prod_q} + (PROD_W + 1)'(part);
  assign clamped = (wl > (PROD_W + 1)'(cap_q)) ? cap_q : wl[WIN_W-1:0];
  assign diff    = clamped - nc_q;
  assign win2    = WIN_W'(r_q) + WIN_W'(ri_q) - WIN_W'(ci_q);

  assign tot = (SUM_W + 1)'(ck_q) + (SUM_W + 1)'(div_quot);
  assign nxt = (tot > (SUM_W + 1)'(RESP_MAX)) ? RESP_MAX : tot[RESP_W-1:0];

  assign miss      = (r_q > RESP_W'(pk_q));
  assign final_res = miss || ((CNT_W'(k_q) + 1'b1) == n_q);
  assign below_m   = (int'(k_q) < int'(m_i));
  assign last_i    = ((i_q + 1'b1) == k_q);
  assign m1        = m_i - 1'b1;
  assign take_init = (int'(m1) > LANES) ? CNT_W'(LANES) : CNT_W'(m1);

  // Sorted insert: lanes hold the largest differences, descending.
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      if (slot_q[j] >= diff) begin
        slot_ins[j] = slot_q[j];
      end else if (j == 0) begin
        slot_ins[j] = diff;
      end else if (slot_q[(j == 0) ? 0 : j - 1] >= diff) begin
        slot_ins[j] = diff;
      end else begin
        slot_ins[j] = slot_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (q_valid_i && q_item_i.last) state_d = S_TASK_RD;
      end
      S_TASK_RD:  state_d = S_TASK_LAT;
      S_TASK_LAT: state_d = below_m ? S_EMIT : S_CHECK;
      S_CHECK:    state_d = miss ? S_EMIT : S_OM_RD;
      S_OM_RD:    state_d = S_OM_LAT;
      S_OM_LAT:   state_d = S_DIV1;
      S_DIV1: begin
        if (!div_busy) state_d = S_MUL1;
      end
      S_MUL1: state_d = S_WL1;
      S_WL1:  state_d = S_DIV2;
      S_DIV2: begin
        if (!div_busy) state_d = S_MUL2;
      end
      S_MUL2: state_d = S_WL2;
      S_WL2:  state_d = last_i ? S_SUMD : S_OM_RD;
      S_SUMD: begin
        if (take_q == '0) state_d = S_DIVM;
      end
      S_DIVM: begin
        if (!div_busy) state_d = (nxt == r_q) ? S_EMIT : S_CHECK;
      end
      S_EMIT: begin
        if (!res_tvalid_o || res_tready_i) state_d = final_res ? S_LOAD : S_TASK_RD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop_o      = 1'b0;
    task_we      = 1'b0;
    resp_we      = 1'b0;
    out_load     = 1'b0;
    raddr        = k_q;
    div_start    = 1'b0;
    div_dividend = SUM_W'(r_q);
    div_divisor  = task_rd[TASK_W-1:TIME_W];
    case (state_q)
      S_LOAD: begin
        q_pop_o = q_valid_i;
        task_we = q_valid_i && q_item_i.keep;
      end
      S_OM_RD: raddr = i_q;
      S_OM_LAT: div_start = 1'b1;
      S_WL1: begin
        div_start    = 1'b1;
        div_dividend = SUM_W'(win2);
        div_divisor  = pi_q;
      end
      S_SUMD: begin
        div_start    = (take_q == '0);
        div_dividend = sum_q;
        div_divisor  = TIME_W'(m_i);
      end
      S_EMIT: begin
        out_load = !res_tvalid_o || res_tready_i;
        resp_we  = out_load;
      end
      default: ;
    endcase
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_TASK_LAT: begin
        ck_q <= task_rd[TIME_W-1:0];
        pk_q <= task_rd[TASK_W-1:TIME_W];
        r_q  <= RESP_W'(task_rd[TIME_W-1:0]);
      end
      S_CHECK: begin
        cap_q <= WIN_W'(r_q) - WIN_W'(ck_q) + 1'b1;
        sum_q <= '0;
        for (int j = 0; j < LANES; j++) slot_q[j] <= '0;
      end
      S_OM_LAT: begin
        ci_q <= task_rd[TIME_W-1:0];
        pi_q <= task_rd[TASK_W-1:TIME_W];
        ri_q <= resp_rd;
      end
      S_DIV1, S_DIV2: begin
        q_q   <= div_quot[WIN_W-1:0];
        rem_q <= div_rem;
      end
      S_MUL1, S_MUL2: prod_q <= q_q * ci_q;
      S_WL1: nc_q <= clamped;
      S_WL2: begin
        sum_q <= sum_q + SUM_W'(nc_q);
        for (int j = 0; j < LANES; j++) slot_q[j] <= slot_ins[j];
        take_q <= take_init;
      end
      S_SUMD: begin
        if (take_q != '0) begin
          sum_q <= sum_q + SUM_W'(slot_q[0]);
          for (int j = 0; j < LANES - 1; j++) slot_q[j] <= slot_q[j + 1];
          slot_q[LANES-1] <= '0;
          take_q <= take_q - 1'b1;
        end
      end
      S_DIVM: begin
        if (!div_busy) r_q <= nxt;
      end
      default: ;
    endcase
    if (out_load) begin
      res_tdata_o <= {r_q, 4'(k_q)};
      res_tuser_o <= miss;
      res_tlast_o <= final_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      tc_q         <= '0;
      n_q          <= '0;
      k_q          <= '0;
      i_q          <= '0;
      res_tvalid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        if (q_item_i.last) begin
          n_q  <= tc_q + CNT_W'(q_item_i.keep);
          tc_q <= '0;
          k_q  <= '0;
        end else begin
          tc_q <= tc_q + CNT_W'(q_item_i.keep);
        end
      end
      if (state_q == S_CHECK) i_q <= '0;
      if (state_q == S_WL2 && !last_i) i_q <= i_q + 1'b1;
      if (out_load && !final_res) k_q <= k_q + 1'b1;
      if (out_load) begin
        res_tvalid_o <= 1'b1;
      end else if (res_tready_i) begin
        res_tvalid_o <= 1'b0;
      end
    end
  end

endmodule

// ===== design/global_fp_response_time_test_top.sv =====
// ----------------------------------------------------------------------------
// global_fp_response_time_test_top
// Global fixed-priority response-time test for implicit-deadline task sets.
// ----------------------------------------------------------------------------
// Feed tasks in decreasing priority order, one word per cycle, each word
// carrying WCET and period; tlast marks the lowest-priority task and starts
// the analysis on the number of processors held in the processors register
// (address 0, reset 1, zero acts as one). Up to 16 tasks are kept; further
// tasks of the same set are dropped. Loading runs at one word per cycle
// unless the queue is full. After tlast the block emits one result word per
// task in priority order (index, saturated response bound, miss flag in
// tuser, tlast on the final word) and stops at the first miss. Tasks below
// the processor count take R = C without iterating. Every other task
// iterates; each iteration divides twice for every higher-priority task
// and once by m, on the shared serial divider that yields one quotient bit
// per cycle (SUM_W = 26). During analysis the two-entry task queue fills and
// then the input stalls until the back has issued the final result word.
module global_fp_response_time_test_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Task words
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] wcet, [31:16] period
  input  logic        s_axis_tlast_i,   // last task of the set
  // Result words
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [3:0] task_index, [23:4] response
  output logic        m_axis_tuser_o,   // misses
  output logic        m_axis_tlast_o,   // final_res
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gfprt_pkg::*;

  logic [PROC_W-1:0] proc_q;
  logic [PROC_W-1:0] m_eff;
  logic              reg_wr;

  item_t push_item, pop_item;
  logic  push, full, pop, q_valid;

  // Registers take a write on the access cycle; no wait states.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PROCESSORS);
  assign prdata = (paddr[2] == REG_PROCESSORS) ? 32'(proc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_q <= PROC_W'(1);
    end else if (reg_wr) begin
      proc_q <= pwdata[PROC_W-1:0];
    end
  end

  // Treat zero processors as one.
  assign m_eff = (proc_q == '0) ? PROC_W'(1) : proc_q;

  gfprt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tlast_i   (s_axis_tlast_i),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  gfprt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  gfprt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .m_i          (m_eff),
    .q_valid_i    (q_valid),
    .q_item_i     (pop_item),
    .q_pop_o      (pop),
    .res_tvalid_o (m_axis_tvalid_o),
    .res_tready_i (m_axis_tready_i),
    .res_tdata_o  (m_axis_tdata_o),
    .res_tuser_o  (m_axis_tuser_o),
    .res_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== design/gfprt_checker.sv =====
// ----------------------------------------------------------------------------
// gfprt_checker
// Port-level checks of the response-time analysis block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfprt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // A stalled result word holds.
  `ASSERT_HOLD(a_res_hold, m_axis_tvalid_o, m_axis_tready_i, m_axis_tdata_o, "result word changed while stalled")

  // A miss always closes the run.
  `ASSERT_CLK(a_miss_final, (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o, "miss without final flag")

  // A processors write reads back on the next cycle.
  `ASSERT_CLK(a_reg_rd, (psel && penable && pwrite && pready && !paddr[2]) |=> (paddr[2] || (prdata[4:0] == $past(pwdata[4:0]))), "processors readback mismatch")

endmodule

bind global_fp_response_time_test_top gfprt_checker u_gfprt_checker (.*);
